>>> hw/rtl/url_percent_decoder_core_defines.svh
// assertion macros used by the checker of the url percent decoder
`ifndef URL_PERCENT_DECODER_CORE_DEFINES_SVH
`define URL_PERCENT_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/upd_pkg.sv
package upd_pkg;

	// characters the decoder looks for or produces
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// configuration register indexes
	localparam logic CFG_PLUS   = 1'b0;
	localparam logic CFG_MARKUP = 1'b1;

	// symbols one input byte can leave behind, before entity expansion
	localparam int MAX_SYM = 3;

	typedef struct packed {
		logic [MAX_SYM-1:0][7:0] sym;
		logic [1:0]              nsym;
		logic                    last;
	} upd_item_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	// nibble of a valid hex digit
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c <= "9") return c[3:0];
		return 4'(c[3:0] + 4'd9);
	endfunction

	// number of bytes a symbol turns into
	function automatic logic [2:0] ent_len(input logic [7:0] c, input logic markup);
		if (markup && c == CH_AMP) return 3'd5;
		if (markup && (c == CH_LT || c == CH_GT)) return 3'd4;
		return 3'd1;
	endfunction

	// byte idx of the expansion of a symbol
	function automatic logic [7:0] ent_char(input logic [7:0] c, input logic markup,
			input logic [2:0] idx);
		logic [7:0] r;
		r = c;
		if (markup && c == CH_AMP) begin
			case (idx)
				3'd0: r = "&";
				3'd1: r = "a";
				3'd2: r = "m";
				3'd3: r = "p";
				default: r = ";";
			endcase
		end else if (markup && (c == CH_LT || c == CH_GT)) begin
			case (idx)
				3'd0: r = "&";
				3'd1: r = (c == CH_LT) ? "l" : "g";
				3'd2: r = "t";
				default: r = ";";
			endcase
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/upd_parser.sv
module upd_parser
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       take,
	input  logic       plus_to_space,
	output upd_item_t  item
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	phase_t     ph_q, ph_nx;
	logic [7:0] held_q, held_nx;
	logic [MAX_SYM-1:0][7:0] sym;
	logic [1:0] n;
	logic       b_hex;
	logic       fresh_pct;
	logic [7:0] fresh_byte;

	assign b_hex      = is_hex(in_byte);
	assign fresh_pct  = (in_byte == CH_PCT);
	assign fresh_byte = (in_byte == CH_PLUS && plus_to_space) ? CH_SPACE : in_byte;

	always_comb begin
		sym     = '0;
		n       = '0;
		ph_nx   = ph_q;
		held_nx = held_q;
		unique case (ph_q)
			PH_PCT: begin
				if (b_hex) begin
					held_nx = in_byte;
					ph_nx   = PH_DIGIT;
				end else begin
					// broken escape: literal percent, then the byte afresh
					sym[n] = CH_PCT;
					n      = n + 2'd1;
					ph_nx  = PH_IDLE;
					if (fresh_pct) begin
						ph_nx = PH_PCT;
					end else begin
						sym[n] = fresh_byte;
						n      = n + 2'd1;
					end
				end
			end
			PH_DIGIT: begin
				ph_nx   = PH_IDLE;
				held_nx = '0;
				if (b_hex) begin
					sym[n] = {hex_val(held_q), hex_val(in_byte)};
					n      = n + 2'd1;
				end else begin
					sym[n] = CH_PCT;
					n      = n + 2'd1;
					sym[n] = held_q;
					n      = n + 2'd1;
					if (fresh_pct) begin
						ph_nx = PH_PCT;
					end else begin
						sym[n] = fresh_byte;
						n      = n + 2'd1;
					end
				end
			end
			default: begin
				// idle, and the unused code behaves the same
				ph_nx = PH_IDLE;
				if (fresh_pct) begin
					ph_nx = PH_PCT;
				end else begin
					sym[n] = fresh_byte;
					n      = n + 2'd1;
				end
			end
		endcase
		// end of string flushes a pending escape literally
		if (in_last) begin
			if (ph_nx == PH_PCT) begin
				sym[n] = CH_PCT;
				n      = n + 2'd1;
			end else if (ph_nx == PH_DIGIT) begin
				sym[n] = CH_PCT;
				n      = n + 2'd1;
				sym[n] = held_nx;
				n      = n + 2'd1;
			end
			ph_nx   = PH_IDLE;
			held_nx = '0;
		end
	end

	assign item.sym  = sym;
	assign item.nsym = n;
	assign item.last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			held_q <= '0;
		end else if (take) begin
			ph_q   <= ph_nx;
			held_q <= held_nx;
		end
	end

endmodule

>>> hw/rtl/url_percent_decoder_core.sv
// output: registered; an accepted item loads cur_q, or the skid slot while cur_q is busy
// throughput: one input byte per cycle while each byte yields at most one output byte and
//   the output is not stalled; longer expansions (up to 7 output bytes per input) go out
//   one byte at a time through the single output byte lane of the entity expander
// reset: async active low; escape state cleared, plus_to_space = 1, escape_markup = 0
module url_percent_decoder_core
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// encoded input stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	// decoded output stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // out_last
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	logic       plus_to_space_q;
	logic       escape_markup_q;

	// parsed item for the byte on the input side
	upd_item_t  new_item;
	logic       s_xfer;
	logic       new_has;

	// current item being expanded onto the output, plus one skid slot
	upd_item_t  cur_q, skid_q;
	logic       cur_valid_q, skid_valid_q;
	logic [1:0] sym_idx_q;
	logic [2:0] chr_idx_q;

	logic [7:0] cur_sym;
	logic [2:0] cur_len;
	logic       last_chr, last_sym;
	logic       m_xfer, done, free;

	// configuration registers; the user must write them only while the stream is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_to_space_q <= 1'b1;
			escape_markup_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PLUS:   plus_to_space_q <= cfg_data;
				CFG_MARKUP: escape_markup_q <= cfg_data;
			endcase
		end
	end

	// input side is ready as long as the skid slot is empty
	assign s_axis_tready = !skid_valid_q;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;
	// bytes that only open an escape or hold its first digit leave nothing to send
	assign new_has       = s_xfer && (new_item.nsym != 2'd0);

	upd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (s_axis_tdata),
		.in_last       (s_axis_tlast),
		.take          (s_xfer),
		.plus_to_space (plus_to_space_q),
		.item          (new_item)
	);

	// expander: walks the symbols of the current item, each symbol over its entity text
	assign cur_sym  = cur_q.sym[sym_idx_q];
	assign cur_len  = ent_len(cur_sym, escape_markup_q);
	assign last_chr = (chr_idx_q == cur_len - 3'd1);
	assign last_sym = (sym_idx_q == cur_q.nsym - 2'd1);
	assign m_xfer   = m_axis_tvalid && m_axis_tready;
	assign done     = m_xfer && last_chr && last_sym;
	assign free     = !cur_valid_q || done;

	assign m_axis_tvalid = cur_valid_q;
	assign m_axis_tdata  = ent_char(cur_sym, escape_markup_q, chr_idx_q);
	assign m_axis_tlast  = cur_q.last && last_chr && last_sym;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			sym_idx_q    <= '0;
			chr_idx_q    <= '0;
		end else if (free) begin
			sym_idx_q <= '0;
			chr_idx_q <= '0;
			if (skid_valid_q) begin
				// input is stalled while the skid slot is full
				cur_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				cur_valid_q <= new_has;
			end
		end else begin
			if (m_xfer) begin
				if (last_chr) begin
					chr_idx_q <= '0;
					sym_idx_q <= sym_idx_q + 2'd1;
				end else begin
					chr_idx_q <= chr_idx_q + 3'd1;
				end
			end
			if (new_has) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (free) begin
			if (skid_valid_q) begin
				cur_q <= skid_q;
			end else if (new_has) begin
				cur_q <= new_item;
			end
		end else if (new_has) begin
			skid_q <= new_item;
		end
	end

endmodule

>>> hw/rtl/upd_checker.sv
`include "url_percent_decoder_core_defines.svh"

module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// a stalled output transaction keeps its payload
	`UPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

	// input only backs up when output has something waiting
	`UPD_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input stalled with output empty")

	// the last input byte always leaves a result behind
	`UPD_ASSERT_NEXT(a_last_out, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no output after last input byte")

	// configuration port never backpressures
	`UPD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (.*);

>>> bench/url_percent_decoder_core_tb.sv
`timescale 1ns / 100ps

module url_percent_decoder_core_tb
	import upd_pkg::*;
();

	localparam int CLK_PERIOD   = 12;
	localparam int RANDOM_ITEMS = 350;
	localparam int DIR_ROWS     = 32;
	localparam int MAX_OUT      = 7;

	// escape tracking of the predictor, phase code 3 never arises
	typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_state_t;

	// one decoded output byte as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_rec_t;

	// directed stimulus row, either a register update or one input byte
	typedef struct packed {
		logic        is_cfg;
		logic        plus;
		logic        markup;
		logic [7:0]  data;
		logic        last;
		int          n_typed;   // -1: expected bytes come from the predictor
		logic [55:0] typed;     // typed expected text, right aligned
	} dir_row_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast  = 1'b0;    // in_last
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [7:0] out_byte
	logic       m_axis_tlast;            // out_last
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic       cfg_index     = 1'b0;
	logic       cfg_data      = 1'b0;

	// predictor copy of the block state and registers
	logic       plus_mode   = 1'b1;
	logic       markup_mode = 1'b0;
	esc_state_t esc_state   = ESC_IDLE;
	logic [7:0] held_digit  = 8'h00;

	out_rec_t   step_out[$];      // bytes caused by the current input byte
	out_rec_t   decoded_q[$];     // decoded bytes still to arrive
	out_rec_t   want;
	logic [7:0] text_q[$];        // encoded string being composed
	int         fail_count   = 0;
	int         src_idle_pct = 0;
	int         dst_idle_pct = 0;

	// directed part: extremes and each escape case, then every register setting
	dir_row_t dir_tab [DIR_ROWS] = '{
		// reset settings: plus to space on, markup off
		'{1'b0, 1'b0, 1'b0, 8'h00, 1'b0,  1, 56'h00},
		'{1'b0, 1'b0, 1'b0, 8'hFF, 1'b0,  1, 56'hFF},
		'{1'b0, 1'b0, 1'b0, "+",   1'b0,  1, " "},
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "4",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "1",   1'b0,  1, "A"},
		// decoded plus is never turned into a space
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "2",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "B",   1'b0,  1, "+"},
		// escape broken right after the percent sign
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "g",   1'b0,  2, "%g"},
		// escape broken after one digit
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "f",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "Z",   1'b0,  3, "%fZ"},
		// breaking percent starts a new escape, flushed with its digit at end of string
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  1, "%"},
		'{1'b0, 1'b0, 1'b0, "7",   1'b1,  2, "%7"},
		// plus passes, markup expands
		'{1'b1, 1'b0, 1'b1, 8'h00, 1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "+",   1'b0,  1, "+"},
		'{1'b0, 1'b0, 1'b0, "&",   1'b0,  5, "&amp;"},
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "3",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "c",   1'b0,  4, "&lt;"},
		'{1'b0, 1'b0, 1'b0, ">",   1'b0, -1, 56'h00},
		// longest expansion of one byte, ending the string
		'{1'b0, 1'b0, 1'b0, "%",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "a",   1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "&",   1'b1,  7, "%a&amp;"},
		// both on, lone percent as final byte
		'{1'b1, 1'b1, 1'b1, 8'h00, 1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "+",   1'b0, -1, 56'h00},
		'{1'b0, 1'b0, 1'b0, "%",   1'b1,  1, "%"},
		// both off
		'{1'b1, 1'b0, 1'b0, 8'h00, 1'b0,  0, 56'h00},
		'{1'b0, 1'b0, 1'b0, "<",   1'b1, -1, 56'h00}
	};

	url_percent_decoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// value of a hex digit of either case, -1 for any other byte
	function automatic int digit_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	// one output byte, at most seven per input byte
	function automatic void emit_raw(input logic [7:0] c);
		out_rec_t rec;
		if (step_out.size() >= MAX_OUT) return;
		rec.data = c;
		rec.last = 1'b0;
		step_out = {step_out, rec};
	endfunction

	function automatic void emit_text(input string s);
		for (int i = 0; i < s.len(); i++) emit_raw(s[i]);
	endfunction

	// emitted byte, with entity expansion when markup is on
	function automatic void emit_char(input logic [7:0] c);
		if (markup_mode && c == CH_AMP) emit_text("&amp;");
		else if (markup_mode && c == CH_LT) emit_text("&lt;");
		else if (markup_mode && c == CH_GT) emit_text("&gt;");
		else emit_raw(c);
	endfunction

	// byte seen with no escape pending
	function automatic void take_fresh(input logic [7:0] c);
		if (c == CH_PCT) esc_state = ESC_PCT;
		else if (c == CH_PLUS && plus_mode) emit_char(CH_SPACE);
		else emit_char(c);
	endfunction

	// decoded bytes caused by one accepted input byte
	function automatic void predict_step(input logic [7:0] c, input logic fin);
		int         d;
		int         h;
		logic [7:0] first;
		step_out.delete();
		d = digit_val(c);
		case (esc_state)
			ESC_PCT: begin
				if (d >= 0) begin
					held_digit = c;
					esc_state  = ESC_DIGIT;
				end else begin
					esc_state = ESC_IDLE;
					emit_char(CH_PCT);
					take_fresh(c);
				end
			end
			ESC_DIGIT: begin
				first      = held_digit;
				h          = digit_val(first);
				esc_state  = ESC_IDLE;
				held_digit = 8'h00;
				if (d >= 0 && h >= 0) begin
					emit_char(8'((h << 4) | d));
				end else begin
					emit_char(CH_PCT);
					emit_char(first);
					take_fresh(c);
				end
			end
			default: begin
				esc_state = ESC_IDLE;
				take_fresh(c);
			end
		endcase
		if (fin) begin
			// pending escape goes out literally at end of string
			if (esc_state == ESC_PCT) begin
				emit_char(CH_PCT);
			end else if (esc_state == ESC_DIGIT) begin
				emit_char(CH_PCT);
				emit_char(held_digit);
			end
			esc_state  = ESC_IDLE;
			held_digit = 8'h00;
			if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'(int'("0") + v);
		if ($urandom_range(1)) return 8'(int'("a") + v - 10);
		return 8'(int'("A") + v - 10);
	endfunction

	// encoded string: mostly escapes and special characters, sometimes pure noise
	task automatic compose_string();
		logic [7:0] c;
		text_q.delete();
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 8)) text_q = {text_q, 8'($urandom_range(255))};
		end else begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(9))
					0, 1, 2: begin
						// well-formed escape
						text_q = {text_q, CH_PCT};
						text_q = {text_q, rand_hex_char()};
						text_q = {text_q, rand_hex_char()};
					end
					3: begin
						// escape broken at once
						do c = 8'($urandom_range(255)); while (digit_val(c) >= 0);
						text_q = {text_q, CH_PCT};
						text_q = {text_q, c};
					end
					4: begin
						// escape that may break after one digit
						text_q = {text_q, CH_PCT};
						text_q = {text_q, rand_hex_char()};
						text_q = {text_q, 8'($urandom_range(255))};
					end
					5: begin
						case ($urandom_range(4))
							0: text_q = {text_q, CH_PLUS};
							1: text_q = {text_q, CH_AMP};
							2: text_q = {text_q, CH_LT};
							3: text_q = {text_q, CH_GT};
							default: text_q = {text_q, CH_PCT};
						endcase
					end
					6, 7: text_q = {text_q, 8'($urandom_range(8'h7E, 8'h20))};
					8: text_q = {text_q, 8'($urandom_range(255))};
					default: text_q = {text_q, rand_hex_char()};
				endcase
			end
		end
	endtask

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	// one input transaction, expectations queued at acceptance
	task automatic send_item(input logic [7:0] c, input logic fin, input int n_typed,
			input logic [55:0] typed);
		out_rec_t rec;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		predict_step(c, fin);
		if (n_typed < 0) begin
			foreach (step_out[k]) decoded_q = {decoded_q, step_out[k]};
		end else begin
			for (int k = 0; k < n_typed; k++) begin
				rec.data = typed[8 * (n_typed - 1 - k) +: 8];
				rec.last = fin && (k == n_typed - 1);
				decoded_q = {decoded_q, rec};
			end
		end
	endtask

	// stop sending and let every pending output drain
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PLUS) plus_mode = val;
		else markup_mode = val;
	endtask

	task automatic apply_config(input logic plus, input logic markup);
		settle_block();
		write_reg(CFG_PLUS, plus);
		write_reg(CFG_MARKUP, markup);
		cfg_valid <= 1'b0;
	endtask

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// output checker, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				log_failure($sformatf("unexpected output transaction: data %02h last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
					log_failure($sformatf(
						"output mismatch: expected data %02h last %0b, got data %02h last %0b",
						want.data, want.last, m_axis_tdata, m_axis_tlast));
			end
		end
	end

	// stimulus
	initial begin
		int sent;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the first idling mix
		src_idle_pct = 30;
		dst_idle_pct = 68;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				apply_config(dir_tab[i].plus, dir_tab[i].markup);
			else
				send_item(dir_tab[i].data, dir_tab[i].last, dir_tab[i].n_typed,
					dir_tab[i].typed);
		end

		// random strings, three idling mixes, settings sometimes changed between strings
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 30;
					dst_idle_pct = 68;
				end
				1: begin
					src_idle_pct = 68;
					dst_idle_pct = 30;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				if ($urandom_range(3) == 0)
					apply_config(1'($urandom_range(1)), 1'($urandom_range(1)));
				compose_string();
				foreach (text_q[k])
					send_item(text_q[k], k == text_q.size() - 1, -1, 56'h00);
				sent += text_q.size();
			end
		end

		settle_block();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * 200000);
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/upd_pkg.sv
hw/rtl/upd_parser.sv
hw/rtl/url_percent_decoder_core.sv
hw/rtl/upd_checker.sv
bench/url_percent_decoder_core_tb.sv
